// File: rtl/core/atb_pkg.sv
// Package for the ATA task-file command builder: payload and job types,
// register indexes, error codes, opcodes and the divide-by-63 constants.
// No dependencies.
`timescale 1ns / 1ps

package atb_pkg;

	// Default depth of the job queue between front and back end
	localparam int QUEUE_DEPTH_DEF = 4;

	// Task-file register indexes
	localparam logic [2:0] REG_COUNT    = 3'd0;
	localparam logic [2:0] REG_LBA_LOW  = 3'd1;
	localparam logic [2:0] REG_LBA_MID  = 3'd2;
	localparam logic [2:0] REG_LBA_HIGH = 3'd3;
	localparam logic [2:0] REG_DRIVE    = 3'd4;
	localparam logic [2:0] REG_COMMAND  = 3'd5;
	localparam logic [2:0] REG_CONTROL  = 3'd6;

	// Error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_NO_DEVICE = 2'd1;
	localparam logic [1:0] ERR_RANGE     = 2'd2;
	localparam logic [1:0] ERR_NO_LBA48  = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_DEVICE_PRESENT = 3'd0;
	localparam logic [2:0] CFG_LAST_BLOCK     = 3'd1;
	localparam logic [2:0] CFG_LBA28_CAPABLE  = 3'd2;
	localparam logic [2:0] CFG_LBA48_CAPABLE  = 3'd3;
	localparam logic [2:0] CFG_SLAVE_DEVICE   = 3'd4;
	localparam logic [2:0] CFG_DMA_ENABLED    = 3'd5;
	localparam logic [2:0] CFG_CONTROL_BASE   = 3'd6;

	// Command opcodes
	localparam logic [7:0] CMD_READ_PIO      = 8'h20;
	localparam logic [7:0] CMD_READ_DMA      = 8'hC8;
	localparam logic [7:0] CMD_WRITE_PIO     = 8'h30;
	localparam logic [7:0] CMD_WRITE_DMA     = 8'hCA;
	localparam logic [7:0] CMD_READ_PIO_EXT  = 8'h24;
	localparam logic [7:0] CMD_READ_DMA_EXT  = 8'h25;
	localparam logic [7:0] CMD_WRITE_PIO_EXT = 8'h34;
	localparam logic [7:0] CMD_WRITE_DMA_EXT = 8'h35;

	// Drive select base values
	localparam logic [7:0] SEL_CHS = 8'hA0;
	localparam logic [7:0] SEL_LBA = 8'hE0;

	// Control register bits
	localparam logic [7:0] CTL_NIEN_CLR = 8'hFD;
	localparam logic [7:0] CTL_HOB_SET  = 8'h80;
	localparam logic [7:0] CTL_HOB_CLR  = 8'h7F;

	// x / 63 for x < 2^28: q = (x * RECIP_63) >> RECIP_SHIFT, low by at most one
	localparam logic [28:0] RECIP_63    = 29'd272696336;
	localparam int          RECIP_SHIFT = 34;
	localparam logic [6:0]  SECT_PER_TRK = 7'd63;

	typedef struct packed {
		logic        direction;
		logic [31:0] block_address;
		logic [7:0]  sector_count;
	} req_t;

	typedef struct packed {
		logic [2:0] register_index;
		logic [7:0] register_value;
		logic [1:0] error_code;
		logic       last;
	} res_t;

	typedef struct packed {
		logic        device_present;
		logic [31:0] last_block;
		logic        lba28_capable;
		logic        lba48_capable;
		logic        slave_device;
		logic        dma_enabled;
		logic [7:0]  control_base;
	} cfg_t;

	// Classified request, ready for the write sequencer
	typedef struct packed {
		logic [1:0] err;
		logic       lba48;
		logic [7:0] ctl;
		logic [7:0] sel;
		logic [7:0] hob_low;
		logic [7:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] cmd;
	} job_t;

endpackage

// File: rtl/core/atb_front.sv
// Front end: registers a request, checks it, picks the addressing mode and
// computes CHS geometry over two stages. Depends on atb_pkg.
`timescale 1ns / 1ps

module atb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  atb_pkg::req_t req,
	input  atb_pkg::cfg_t cfg,
	output logic          push,
	output atb_pkg::job_t job
);

	logic          valid_s1;
	atb_pkg::req_t req_s1;

	logic          valid_s2;
	atb_pkg::req_t req_s2;
	logic [1:0]    err_s2;
	logic          lba48_s2;
	logic          chs_s2;
	logic [22:0]   quot_s2;

	logic [1:0]    err_c;
	logic          lba48_c;
	logic [56:0]   prod_c;

	logic [27:0]   mul63_c;
	logic [27:0]   rem_full_c;
	logic [6:0]    rem_c;
	logic          fix_c;
	logic [22:0]   quot_c;
	logic [6:0]    rem_fix_c;
	logic [7:0]    sect_c;
	logic [3:0]    head_c;
	logic [7:0]    cmd_c;

	// Stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
	end

	// Checks, in priority order, and the reciprocal multiply for CHS
	always_comb begin
		lba48_c = (req_s1.block_address[31:28] != 4'd0);
		if (!cfg.device_present) begin
			err_c = atb_pkg::ERR_NO_DEVICE;
		end else if (req_s1.block_address > cfg.last_block) begin
			err_c = atb_pkg::ERR_RANGE;
		end else if (lba48_c && !cfg.lba48_capable) begin
			err_c = atb_pkg::ERR_NO_LBA48;
		end else begin
			err_c = atb_pkg::ERR_NONE;
		end
	end

	assign prod_c = 57'(req_s1.block_address[27:0]) * 57'(atb_pkg::RECIP_63);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			req_s2   <= req_s1;
			err_s2   <= err_c;
			lba48_s2 <= lba48_c;
			chs_s2   <= !lba48_c && !cfg.lba28_capable;
			quot_s2  <= prod_c[56:atb_pkg::RECIP_SHIFT];
		end
	end

	// Remainder and one-step quotient correction
	assign mul63_c    = {quot_s2[21:0], 6'd0} - {5'd0, quot_s2};
	assign rem_full_c = req_s2.block_address[27:0] - mul63_c;
	assign rem_c      = rem_full_c[6:0];
	assign fix_c      = (rem_c >= atb_pkg::SECT_PER_TRK);
	assign quot_c     = fix_c ? quot_s2 + 23'd1 : quot_s2;
	assign rem_fix_c  = fix_c ? rem_c - atb_pkg::SECT_PER_TRK : rem_c;
	assign sect_c     = {1'b0, rem_fix_c} + 8'd1;

	// Head nibble of drive select
	always_comb begin
		if (lba48_s2) begin
			head_c = 4'd0;
		end else if (chs_s2) begin
			head_c = quot_c[3:0];
		end else begin
			head_c = req_s2.block_address[27:24];
		end
	end

	// Opcode selection
	always_comb begin
		case ({lba48_s2, req_s2.direction, cfg.dma_enabled})
			3'b000:  cmd_c = atb_pkg::CMD_READ_PIO;
			3'b001:  cmd_c = atb_pkg::CMD_READ_DMA;
			3'b010:  cmd_c = atb_pkg::CMD_WRITE_PIO;
			3'b011:  cmd_c = atb_pkg::CMD_WRITE_DMA;
			3'b100:  cmd_c = atb_pkg::CMD_READ_PIO_EXT;
			3'b101:  cmd_c = atb_pkg::CMD_READ_DMA_EXT;
			3'b110:  cmd_c = atb_pkg::CMD_WRITE_PIO_EXT;
			3'b111:  cmd_c = atb_pkg::CMD_WRITE_DMA_EXT;
			default: cmd_c = atb_pkg::CMD_READ_PIO;
		endcase
	end

	// Job assembly
	always_comb begin
		job.err     = err_s2;
		job.lba48   = lba48_s2;
		job.ctl     = cfg.control_base & atb_pkg::CTL_NIEN_CLR;
		job.sel     = {3'd0, cfg.slave_device, 4'd0}
			| (chs_s2 ? atb_pkg::SEL_CHS : atb_pkg::SEL_LBA) | {4'd0, head_c};
		job.hob_low = req_s2.block_address[31:24];
		job.cnt     = req_s2.sector_count;
		if (chs_s2) begin
			job.b0 = sect_c;
			job.b1 = quot_c[11:4];
			job.b2 = quot_c[19:12];
		end else begin
			job.b0 = req_s2.block_address[7:0];
			job.b1 = req_s2.block_address[15:8];
			job.b2 = req_s2.block_address[23:16];
		end
		job.cmd     = cmd_c;
	end

	assign push = valid_s2;

endmodule

// File: rtl/core/atb_queue.sv
// Small FIFO of classified jobs between front and back end.
// Depends on atb_pkg.
`timescale 1ns / 1ps

module atb_queue #(
	parameter int DEPTH = atb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  atb_pkg::job_t push_job,
	input  logic          pop,
	output logic          valid,
	output atb_pkg::job_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	atb_pkg::job_t   mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	// Pointer and fill tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

endmodule

// File: rtl/core/atb_back.sv
// Back end: walks the task-file write sequence of the job at the queue head,
// one register write per cycle, into a registered result. Depends on atb_pkg.
`timescale 1ns / 1ps

module atb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  atb_pkg::job_t job,
	output logic          pop,
	output logic          res_strobe,
	output atb_pkg::res_t res
);

	// Sequencer steps
	localparam logic [3:0] ST_CTL      = 4'd0;
	localparam logic [3:0] ST_SEL      = 4'd1;
	localparam logic [3:0] ST_HOB_CTL  = 4'd2;
	localparam logic [3:0] ST_HOB_CNT  = 4'd3;
	localparam logic [3:0] ST_HOB_LOW  = 4'd4;
	localparam logic [3:0] ST_HOB_MID  = 4'd5;
	localparam logic [3:0] ST_HOB_HIGH = 4'd6;
	localparam logic [3:0] ST_CTL_LOW  = 4'd7;
	localparam logic [3:0] ST_CNT      = 4'd8;
	localparam logic [3:0] ST_LOW      = 4'd9;
	localparam logic [3:0] ST_MID      = 4'd10;
	localparam logic [3:0] ST_HIGH     = 4'd11;
	localparam logic [3:0] ST_CMD      = 4'd12;

	logic [3:0]    step_q;
	logic          failed;
	atb_pkg::res_t cur;

	assign failed = (job.err != atb_pkg::ERR_NONE);

	// Current write
	always_comb begin
		cur.error_code = job.err;
		cur.last       = failed || (step_q == ST_CMD);
		case (step_q)
			ST_CTL:      begin cur.register_index = atb_pkg::REG_CONTROL;
			             cur.register_value = job.ctl; end
			ST_SEL:      begin cur.register_index = atb_pkg::REG_DRIVE;
			             cur.register_value = job.sel; end
			ST_HOB_CTL:  begin cur.register_index = atb_pkg::REG_CONTROL;
			             cur.register_value = job.ctl | atb_pkg::CTL_HOB_SET; end
			ST_HOB_CNT:  begin cur.register_index = atb_pkg::REG_COUNT;
			             cur.register_value = 8'd0; end
			ST_HOB_LOW:  begin cur.register_index = atb_pkg::REG_LBA_LOW;
			             cur.register_value = job.hob_low; end
			ST_HOB_MID:  begin cur.register_index = atb_pkg::REG_LBA_MID;
			             cur.register_value = 8'd0; end
			ST_HOB_HIGH: begin cur.register_index = atb_pkg::REG_LBA_HIGH;
			             cur.register_value = 8'd0; end
			ST_CTL_LOW:  begin cur.register_index = atb_pkg::REG_CONTROL;
			             cur.register_value = job.ctl & atb_pkg::CTL_HOB_CLR; end
			ST_CNT:      begin cur.register_index = atb_pkg::REG_COUNT;
			             cur.register_value = job.cnt; end
			ST_LOW:      begin cur.register_index = atb_pkg::REG_LBA_LOW;
			             cur.register_value = job.b0; end
			ST_MID:      begin cur.register_index = atb_pkg::REG_LBA_MID;
			             cur.register_value = job.b1; end
			ST_HIGH:     begin cur.register_index = atb_pkg::REG_LBA_HIGH;
			             cur.register_value = job.b2; end
			ST_CMD:      begin cur.register_index = atb_pkg::REG_COMMAND;
			             cur.register_value = job.cmd; end
			default:     begin cur.register_index = atb_pkg::REG_COUNT;
			             cur.register_value = 8'd0; end
		endcase
		// a rejected request gives one zero write to the count register
		if (failed) begin
			cur.register_index = atb_pkg::REG_COUNT;
			cur.register_value = 8'd0;
		end
	end

	assign pop = job_valid && cur.last;

	// Step advance; non-LBA48 jobs skip the high-order block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_CTL;
		end else if (job_valid) begin
			if (cur.last) begin
				step_q <= ST_CTL;
			end else if (step_q == ST_SEL && !job.lba48) begin
				step_q <= ST_CNT;
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_strobe <= 1'b0;
		end else begin
			res_strobe <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid) begin
			res <= cur;
		end
	end

endmodule

// File: rtl/core/ata_taskfile_command_builder.sv
// Top level of the ATA task-file command builder: configuration registers,
// admission control, and the front end / job queue / back end chain.
// Depends on atb_pkg, atb_front, atb_queue, atb_back.
//
//   channel   signals                        direction  transfer when
//   request   start, busy, request           in         start && !busy
//   result    result_strobe, result          out        result_strobe (one cycle)
//   config    cfg_we, cfg_index, cfg_data    in         cfg_we
//
// A request gives 13 writes for LBA48, 7 for LBA28 or CHS, and 1 when a
// check fails; the back-end sequencer issues one write per cycle, which
// sets the sustained rate. The first write passes the two front stages,
// the queue and the output register before it reaches the result ports.
// Requests are taken back to back until the queue plus the two front stages
// hold QUEUE_DEPTH jobs; busy is then high. Reset clears the configuration
// to zero and empties the pipeline. Results cannot be held off.
`timescale 1ns / 1ps

module ata_taskfile_command_builder #(
	parameter int QUEUE_DEPTH = atb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  atb_pkg::req_t request,
	output logic          result_strobe,
	output atb_pkg::res_t result,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	localparam int OW = $clog2(QUEUE_DEPTH + 1);

	atb_pkg::cfg_t cfg_q;
	logic [OW-1:0] occ_q;
	logic          take;
	logic          push;
	logic          pop;
	logic          job_valid;
	atb_pkg::job_t front_job;
	atb_pkg::job_t head_job;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				atb_pkg::CFG_DEVICE_PRESENT: cfg_q.device_present <= cfg_data[0];
				atb_pkg::CFG_LAST_BLOCK:     cfg_q.last_block     <= cfg_data;
				atb_pkg::CFG_LBA28_CAPABLE:  cfg_q.lba28_capable  <= cfg_data[0];
				atb_pkg::CFG_LBA48_CAPABLE:  cfg_q.lba48_capable  <= cfg_data[0];
				atb_pkg::CFG_SLAVE_DEVICE:   cfg_q.slave_device   <= cfg_data[0];
				atb_pkg::CFG_DMA_ENABLED:    cfg_q.dma_enabled    <= cfg_data[0];
				atb_pkg::CFG_CONTROL_BASE:   cfg_q.control_base   <= cfg_data[7:0];
				default:                     cfg_q                <= cfg_q;
			endcase
		end
	end

	// Jobs in flight: front stages plus queue, bounded by queue depth
	assign busy = (occ_q == OW'(QUEUE_DEPTH));
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (take && !pop) begin
			occ_q <= occ_q + OW'(1);
		end else if (pop && !take) begin
			occ_q <= occ_q - OW'(1);
		end
	end

	atb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (request),
		.cfg    (cfg_q),
		.push   (push),
		.job    (front_job)
	);

	atb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (front_job),
		.pop      (pop),
		.valid    (job_valid),
		.head     (head_job)
	);

	atb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (head_job),
		.pop        (pop),
		.res_strobe (result_strobe),
		.res        (result)
	);

	// Checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(QUEUE_DEPTH))
		else $error("in-flight job count exceeds queue depth");

	a_pop_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> job_valid && occ_q != '0)
		else $error("job retired with none in flight");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.error_code != atb_pkg::ERR_NONE |->
		result.last && result.register_index == atb_pkg::REG_COUNT
		&& result.register_value == 8'd0)
		else $error("error result not a single zero write");

	a_take_counts: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> occ_q != '0)
		else $error("transfer not counted as in flight");

endmodule

// File: test/ata_taskfile_command_builder_tb.sv
// Testbench for ata_taskfile_command_builder: drives sector requests and
// configuration writes, predicts every task-file write and checks each one.
// Depends on atb_pkg and the ata_taskfile_command_builder RTL.
`timescale 1ns / 1ps

module ata_taskfile_command_builder_tb;
	import atb_pkg::*;

	// Index with no register behind it; writes to it must change nothing
	localparam logic [2:0] CFG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 33;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        request = '0;
	logic        result_strobe;
	res_t        result;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	res_t pending_writes[$];
	cfg_t shadow_cfg = '0;
	int   mismatch_count = 0;
	int   cycle_count = 0;
	bit   no_idle = 1'b0;

	ata_taskfile_command_builder dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.result_strobe(result_strobe),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock and a single reset at the start
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d writes outstanding",
				cycle_count, pending_writes.size());
			$display("FAIL ata_taskfile_command_builder");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Check each result transfer against the oldest predicted write
	always @(posedge clk) begin
		res_t want;
		if (arst_n && result_strobe) begin
			if (pending_writes.size() == 0) begin
				report_mismatch("unexpected result", int'(result), 0);
			end else begin
				want = pending_writes.pop_front();
				if (result.register_index !== want.register_index)
					report_mismatch("register_index", result.register_index,
						want.register_index);
				if (result.register_value !== want.register_value)
					report_mismatch("register_value", result.register_value,
						want.register_value);
				if (result.error_code !== want.error_code)
					report_mismatch("error_code", result.error_code, want.error_code);
				if (result.last !== want.last)
					report_mismatch("last", result.last, want.last);
			end
		end
	end

	function automatic void add_write(input logic [2:0] idx, input logic [7:0] val,
		input logic [1:0] err, input logic fin);
		res_t w;
		w.register_index = idx;
		w.register_value = val;
		w.error_code = err;
		w.last = fin;
		pending_writes.push_back(w);
	endfunction

	// Predict the task-file writes that one request produces
	function automatic void build_taskfile_writes(input req_t r);
		logic [31:0] lba, sect, base, cyl;
		logic [7:0]  ctl, sel, b0, b1, b2, cmd;
		logic [3:0]  head;
		logic        ext, chs;
		lba = r.block_address;
		ext = 1'b0;
		chs = 1'b0;
		// Checks in priority order: presence, range, 48-bit support
		if (!shadow_cfg.device_present) begin
			add_write(REG_COUNT, 8'h00, ERR_NO_DEVICE, 1'b1);
			return;
		end
		if (lba > shadow_cfg.last_block) begin
			add_write(REG_COUNT, 8'h00, ERR_RANGE, 1'b1);
			return;
		end
		if (lba >= 32'h1000_0000) begin
			if (!shadow_cfg.lba48_capable) begin
				add_write(REG_COUNT, 8'h00, ERR_NO_LBA48, 1'b1);
				return;
			end
			ext = 1'b1;
			b0 = lba[7:0];
			b1 = lba[15:8];
			b2 = lba[23:16];
			head = 4'h0;
		end else if (shadow_cfg.lba28_capable) begin
			b0 = lba[7:0];
			b1 = lba[15:8];
			b2 = lba[23:16];
			head = lba[27:24];
		end else begin
			// CHS: 63 sectors per track, 16 heads, cylinder kept to 16 bits
			chs = 1'b1;
			sect = lba % 63 + 1;
			base = lba - lba % 63;
			cyl = base / 1008;
			b0 = sect[7:0];
			b1 = cyl[7:0];
			b2 = cyl[15:8];
			head = 4'((base % 1008) / 63);
		end

		ctl = shadow_cfg.control_base & CTL_NIEN_CLR;
		add_write(REG_CONTROL, ctl, ERR_NONE, 1'b0);
		sel = (chs ? SEL_CHS : SEL_LBA) | {3'b000, shadow_cfg.slave_device, head};
		add_write(REG_DRIVE, sel, ERR_NONE, 1'b0);

		// High-order bytes with HOB set
		if (ext) begin
			ctl = ctl | CTL_HOB_SET;
			add_write(REG_CONTROL, ctl, ERR_NONE, 1'b0);
			add_write(REG_COUNT, 8'h00, ERR_NONE, 1'b0);
			add_write(REG_LBA_LOW, lba[31:24], ERR_NONE, 1'b0);
			add_write(REG_LBA_MID, 8'h00, ERR_NONE, 1'b0);
			add_write(REG_LBA_HIGH, 8'h00, ERR_NONE, 1'b0);
			ctl = ctl & CTL_HOB_CLR;
			add_write(REG_CONTROL, ctl, ERR_NONE, 1'b0);
		end

		add_write(REG_COUNT, r.sector_count, ERR_NONE, 1'b0);
		add_write(REG_LBA_LOW, b0, ERR_NONE, 1'b0);
		add_write(REG_LBA_MID, b1, ERR_NONE, 1'b0);
		add_write(REG_LBA_HIGH, b2, ERR_NONE, 1'b0);

		if (ext)
			cmd = r.direction ? (shadow_cfg.dma_enabled ? CMD_WRITE_DMA_EXT : CMD_WRITE_PIO_EXT)
				: (shadow_cfg.dma_enabled ? CMD_READ_DMA_EXT : CMD_READ_PIO_EXT);
		else
			cmd = r.direction ? (shadow_cfg.dma_enabled ? CMD_WRITE_DMA : CMD_WRITE_PIO)
				: (shadow_cfg.dma_enabled ? CMD_READ_DMA : CMD_READ_PIO);
		add_write(REG_COMMAND, cmd, ERR_NONE, 1'b1);
	endfunction

	// Mostly no gap, some short ones, a few long
	function automatic int sender_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Send one request; start stays high across back-to-back transfers
	task automatic send_request(input logic dir, input logic [31:0] addr,
		input logic [7:0] cnt);
		int gap;
		req_t r;
		r.direction = dir;
		r.block_address = addr;
		r.sector_count = cnt;
		gap = no_idle ? 0 : sender_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		build_taskfile_writes(r);
	endtask

	// Stop sending and wait until every predicted write has been seen
	task automatic wait_all_written();
		start <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all register indexes while idle; junk fills unused data bits
	task automatic apply_config(input cfg_t c, input bit junk);
		logic [31:0] value;
		wait_all_written();
		for (int i = 0; i < 8; i++) begin
			value = junk ? $urandom : 32'h0;
			case (i[2:0])
				CFG_DEVICE_PRESENT: value[0] = c.device_present;
				CFG_LAST_BLOCK:     value = c.last_block;
				CFG_LBA28_CAPABLE:  value[0] = c.lba28_capable;
				CFG_LBA48_CAPABLE:  value[0] = c.lba48_capable;
				CFG_SLAVE_DEVICE:   value[0] = c.slave_device;
				CFG_DMA_ENABLED:    value[0] = c.dma_enabled;
				CFG_CONTROL_BASE:   value[7:0] = c.control_base;
				CFG_UNUSED:         ;
			endcase
			cfg_we <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data <= value;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		shadow_cfg = c;
	endtask

	// Reset values: no device, so every request fails
	task automatic test_reset_defaults();
		send_request(1'b0, 32'h0000_0000, 8'h01);
		send_request(1'b1, 32'hFFFF_FFFF, 8'hFF);
	endtask

	// Error priority and LBA28 extremes
	task automatic test_checks_and_lba28();
		apply_config(cfg_t'{1'b1, 32'h0FFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, 8'hFF}, 1'b0);
		send_request(1'b0, 32'h1000_0000, 8'h10);   // out of range beats missing LBA48
		send_request(1'b0, 32'h0FFF_FFFF, 8'h00);
		send_request(1'b1, 32'h0FFF_FFFF, 8'hFF);
		send_request(1'b1, 32'h0000_0000, 8'h80);
		apply_config(cfg_t'{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1, 8'h02}, 1'b1);
		send_request(1'b0, 32'h1000_0000, 8'h01);   // no 48-bit support
		send_request(1'b1, 32'h1234_5678, 8'h02);
		send_request(1'b0, 32'h00AB_CDEF, 8'h55);
		send_request(1'b1, 32'h0543_2100, 8'hAA);
	endtask

	// CHS geometry: track and head boundaries, cylinder wrap
	task automatic test_chs();
		apply_config(cfg_t'{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, 8'h5A}, 1'b0);
		send_request(1'b0, 32'd0, 8'h01);
		send_request(1'b1, 32'd62, 8'h02);
		send_request(1'b0, 32'd63, 8'h03);
		send_request(1'b1, 32'd1007, 8'h04);
		send_request(1'b0, 32'd1008, 8'h05);
		send_request(1'b1, 32'h0FFF_FFFF, 8'hFF);
		send_request(1'b0, 32'd66060288, 8'h06);   // first cylinder past 16 bits
		send_request(1'b1, 32'h1000_0000, 8'h07);   // 48-bit even without LBA28
	endtask

	// 48-bit opcodes, DMA and PIO, then a detached device
	task automatic test_lba48();
		apply_config(cfg_t'{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 8'hFD}, 1'b1);
		send_request(1'b0, 32'h1000_0000, 8'h20);
		send_request(1'b1, 32'hFFFF_FFFF, 8'h00);
		send_request(1'b0, 32'h0FFF_FFFF, 8'h01);
		apply_config(cfg_t'{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00}, 1'b0);
		send_request(1'b0, 32'h8000_0000, 8'h08);
		send_request(1'b1, 32'hFEDC_BA98, 8'hF0);
		apply_config(cfg_t'{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF}, 1'b1);
		send_request(1'b1, 32'h0000_0000, 8'h01);
	endtask

	function automatic cfg_t random_cfg(input int phase);
		cfg_t c;
		c.device_present = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 3))
			0: c.last_block = 32'hFFFF_FFFF;
			1: c.last_block = 32'h0FFF_FFFF;
			2: c.last_block = $urandom;
			default: c.last_block = $urandom_range(0, 5000);
		endcase
		c.lba28_capable = 1'($urandom_range(0, 1));
		c.lba48_capable = ($urandom_range(0, 3) != 0);
		c.slave_device = 1'($urandom_range(0, 1));
		c.dma_enabled = 1'($urandom_range(0, 1));
		c.control_base = 8'($urandom);
		// Extreme settings on the first two phases
		if (phase == 0)
			c = cfg_t'{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF};
		else if (phase == 1)
			c = cfg_t'{1'b1, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
		return c;
	endfunction

	function automatic logic [31:0] random_address();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return $urandom & 32'h0FFF_FFFF;
		else if (roll < 55)
			return $urandom_range(0, 5000);
		else if (roll < 80)
			return $urandom;
		return shadow_cfg.last_block + 32'($urandom_range(0, 6)) - 32'd3;
	endfunction

	// Random traffic over several configurations
	task automatic test_random_traffic();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			apply_config(random_cfg(p), p[0]);
			no_idle = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_request(1'($urandom_range(0, 1)), random_address(), 8'($urandom));
				// Let the pipeline empty out in the middle of one phase
				if (p == 4 && n == PHASE_ITEMS / 2)
					wait_all_written();
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_checks_and_lba28();
		test_chs();
		test_lba48();
		test_random_traffic();
		wait_all_written();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS ata_taskfile_command_builder");
		else
			$display("FAIL ata_taskfile_command_builder");
		$finish;
	end

endmodule

// File: files.f
rtl/core/atb_pkg.sv
rtl/core/atb_front.sv
rtl/core/atb_queue.sv
rtl/core/atb_back.sv
rtl/core/ata_taskfile_command_builder.sv
test/ata_taskfile_command_builder_tb.sv
